@@ rtl/core/fpfir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfir_pkg: shared types and constants of the Q15 FIR filter
// Tap count, arithmetic widths, item codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package fpfir_pkg;

  // Number of taps (1 to 256); only slots below 16 can be written
  localparam int TAPS       = 16;
  localparam int SMP_W      = 16;
  localparam int IDX_W      = 4;
  localparam int PROD_W     = 2 * SMP_W;
  localparam int IDX_SLOTS  = 2 ** IDX_W;

  // Adder tree: at least one registered level, leaves padded to a power of two
  localparam int TREE_LVL   = ($clog2(TAPS) < 1) ? 1 : $clog2(TAPS);
  localparam int LEAVES     = 2 ** TREE_LVL;
  localparam int ACC_W      = PROD_W + TREE_LVL;

  // Q15 rounding: half away from zero
  localparam int FRAC_W     = 15;
  localparam int RND_W      = FRAC_W + SMP_W;
  localparam logic [RND_W-1:0] RND_POS = RND_W'(2 ** (FRAC_W - 1));
  localparam logic [RND_W-1:0] RND_NEG = RND_W'(2 ** (FRAC_W - 1) - 1);

  // Input tdata layout, lowest bit first
  localparam int IN_DATA_W  = ((SMP_W + IDX_W + SMP_W + 7) / 8) * 8;

  // Item kind carried in in_tuser
  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_COEF   = 1'b1
  } mode_t;

  // Per-cell control: shift and coefficient shared by all cells, write enable per cell
  typedef struct packed {
    logic                    shift;
    logic                    coef_we;
    logic signed [SMP_W-1:0] coef;
  } cell_ctl_t;

endpackage

@@ rtl/core/fpfir_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfir_cell: one tap of the FIR chain
// Holds one delayed sample and one coefficient, passes its sample to the
// next cell on a shift and registers the product of the new sample and tap.
// ----------------------------------------------------------------------------
module fpfir_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fpfir_pkg::cell_ctl_t                   ctl,
  input  logic signed [fpfir_pkg::SMP_W-1:0]     x_in,
  output logic signed [fpfir_pkg::SMP_W-1:0]     x_out,
  output logic signed [fpfir_pkg::PROD_W-1:0]    prod
);

  logic signed [fpfir_pkg::SMP_W-1:0]  x_r;
  logic signed [fpfir_pkg::SMP_W-1:0]  c_r;
  logic signed [fpfir_pkg::PROD_W-1:0] prod_r;
  logic signed [fpfir_pkg::PROD_W-1:0] prod_nxt;

  // Product of the sample arriving at this tap and its coefficient
  assign prod_nxt = x_in * c_r;

  // Delay and coefficient state, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      c_r <= '0;
    end else begin
      if (ctl.shift) begin
        x_r <= x_in;
      end
      if (ctl.coef_we) begin
        c_r <= ctl.coef;
      end
    end
  end

  // Capture the product with the shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      prod_r <= prod_nxt;
    end
  end

  assign x_out = x_r;
  assign prod  = prod_r;

endmodule

@@ rtl/core/fpfir_sum_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfir_sum_tree: registered adder tree over the tap products
// Heap-indexed nodes, one register level per tree level, advancing on adv.
// ----------------------------------------------------------------------------
module fpfir_sum_tree (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_vld,
  input  logic signed [fpfir_pkg::PROD_W-1:0]    prod [fpfir_pkg::TAPS],
  output logic signed [fpfir_pkg::ACC_W-1:0]     root,
  output logic                                   root_vld
);

  logic signed [fpfir_pkg::ACC_W-1:0] leaf   [fpfir_pkg::LEAVES];
  logic signed [fpfir_pkg::ACC_W-1:0] node_r [1:fpfir_pkg::LEAVES-1];
  logic [fpfir_pkg::TREE_LVL-1:0]     vld_r;

  // Sign-extend the products; pad unused leaves with zero
  for (genvar k = 0; k < fpfir_pkg::LEAVES; k++) begin : g_leaf
    if (k < fpfir_pkg::TAPS) begin : g_used
      assign leaf[k] = fpfir_pkg::ACC_W'(prod[k]);
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  // One adder per node, each registered
  for (genvar i = 1; i < fpfir_pkg::LEAVES; i++) begin : g_node
    if (i >= fpfir_pkg::LEAVES / 2) begin : g_bottom
      always_ff @(posedge clk) begin
        if (adv) begin
          node_r[i] <= leaf[2*i - fpfir_pkg::LEAVES] + leaf[2*i + 1 - fpfir_pkg::LEAVES];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (adv) begin
          node_r[i] <= node_r[2*i] + node_r[2*i + 1];
        end
      end
    end
  end

  // Valid bit per tree level: shift in the product stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= fpfir_pkg::TREE_LVL'({vld_r, in_vld});
    end
  end

  assign root     = node_r[1];
  assign root_vld = vld_r[fpfir_pkg::TREE_LVL-1];

endmodule

@@ rtl/core/fixed_point_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_fir_filter: direct-form FIR filter on Q15 samples
// Chain of tap cells with a loadable coefficient per cell, a registered
// adder tree and a rounding output register.
// ----------------------------------------------------------------------------
//  channel | ports                         | carries
//  --------+-------------------------------+-------------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | sample or coefficient write,
//          | in_tuser                      |   kind in in_tuser
//  result  | out_tvalid/out_tready/out_tdata | filtered Q15 value
//
//  One item per clock in both directions while the output is not stalled;
//  a sample's products are registered at the accepting edge, then pass one
//  register per adder tree level and the rounding register.
//  Coefficient writes take effect for the next sample and give no result.
//  Reset clears the delay line and all coefficients at once.
//  While a result waits and out_tready is low the whole pipeline holds.
// ----------------------------------------------------------------------------
module fixed_point_fir_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] sample, [19:16] tap_index, [35:20] tap_value, [39:36] zero
  input  logic [fpfir_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] mode
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] filtered
  output logic [fpfir_pkg::SMP_W-1:0]           out_tdata
);

  logic                                  adv;
  logic                                  in_acc;
  logic                                  smp_acc;
  logic                                  coef_acc;
  logic signed [fpfir_pkg::SMP_W-1:0]    in_sample;
  logic [fpfir_pkg::IDX_W-1:0]           in_tap_index;
  logic signed [fpfir_pkg::SMP_W-1:0]    in_tap_value;

  logic signed [fpfir_pkg::SMP_W-1:0]    x_link [fpfir_pkg::TAPS];
  logic signed [fpfir_pkg::PROD_W-1:0]   prod   [fpfir_pkg::TAPS];
  fpfir_pkg::cell_ctl_t                  cell_ctl [fpfir_pkg::TAPS];

  logic                                  p_vld_r;
  logic signed [fpfir_pkg::ACC_W-1:0]    root;
  logic                                  root_vld;
  logic [fpfir_pkg::RND_W-1:0]           rnd_sum;

  logic                                  out_vld_r;
  logic [fpfir_pkg::SMP_W-1:0]           out_data_r;
  logic [fpfir_pkg::SMP_W-1:0]           out_data_nxt;

  // Handshake: the pipeline moves whenever the output register can take data
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign smp_acc   = in_acc && (fpfir_pkg::mode_t'(in_tuser) == fpfir_pkg::MODE_SAMPLE);
  assign coef_acc  = in_acc && (fpfir_pkg::mode_t'(in_tuser) == fpfir_pkg::MODE_COEF);

  // Unpack the input item
  assign in_sample    = in_tdata[fpfir_pkg::SMP_W-1:0];
  assign in_tap_index = in_tdata[fpfir_pkg::SMP_W +: fpfir_pkg::IDX_W];
  assign in_tap_value = in_tdata[fpfir_pkg::SMP_W + fpfir_pkg::IDX_W +: fpfir_pkg::SMP_W];

  assign x_link[0] = in_sample;

  // Tap cells: sample ripples one cell per shift
  for (genvar j = 0; j < fpfir_pkg::TAPS; j++) begin : g_tap
    if (j < fpfir_pkg::IDX_SLOTS) begin : g_wr
      assign cell_ctl[j].coef_we = coef_acc && (in_tap_index == fpfir_pkg::IDX_W'(j));
    end else begin : g_nowr
      assign cell_ctl[j].coef_we = 1'b0;
    end
    assign cell_ctl[j].shift = smp_acc;
    assign cell_ctl[j].coef  = in_tap_value;

    if (j < fpfir_pkg::TAPS - 1) begin : g_mid
      fpfir_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl[j]),
        .x_in  (x_link[j]),
        .x_out (x_link[j+1]),
        .prod  (prod[j])
      );
    end else begin : g_last
      fpfir_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl[j]),
        .x_in  (x_link[j]),
        .x_out (),
        .prod  (prod[j])
      );
    end
  end

  // Product stage valid: set by an accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= smp_acc;
    end
  end

  fpfir_sum_tree u_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p_vld_r),
    .prod     (prod),
    .root     (root),
    .root_vld (root_vld)
  );

  // Round half away from zero, keep the low 16 bits after the shift
  assign rnd_sum      = root[fpfir_pkg::RND_W-1:0] +
                        (root[fpfir_pkg::ACC_W-1] ? fpfir_pkg::RND_NEG : fpfir_pkg::RND_POS);
  assign out_data_nxt = rnd_sum[fpfir_pkg::RND_W-1:fpfir_pkg::FRAC_W];

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A coefficient write never enters the product stage; a sample always does
  a_prod_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (p_vld_r == $past(smp_acc)))
    else $error("product stage valid does not match accepted item kind");

  // Tree output holds while the pipeline is stalled
  a_tree_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(root) && $stable(root_vld)))
    else $error("adder tree moved during a stall");

  // A result appears only after the tree presented a valid sum
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(root_vld))
    else $error("result raised without a valid tree sum");

endmodule

@@ tb/sv/fixed_point_fir_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_fir_filter_test: self-checking bench for the Q15 FIR filter
// Drives a short table of directed items, then random sample and coefficient
// items under changing back-pressure, and checks every filtered value against
// its typed-in result or a behavioural model of the tap chain, rounding and 16-bit wrap.
// ----------------------------------------------------------------------------
module fixed_point_fir_filter_test;

  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASE   = 450;
  localparam int REPORT_MAX   = 10;

  // One directed item, with its result typed in where it is obvious
  typedef struct packed {
    fpfir_pkg::mode_t            mode;
    logic [fpfir_pkg::SMP_W-1:0] sample;
    logic [fpfir_pkg::IDX_W-1:0] idx;
    logic [fpfir_pkg::SMP_W-1:0] value;
    logic                        typed;
    logic [fpfir_pkg::SMP_W-1:0] result;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // [15:0] sample, [19:16] tap_index, [35:20] tap_value, [39:36] zero
  logic [fpfir_pkg::IN_DATA_W-1:0] in_tdata;
  // [0] mode
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  // [15:0] filtered
  logic [fpfir_pkg::SMP_W-1:0]     out_tdata;

  // Model state: newest sample first, then the delay line
  logic signed [fpfir_pkg::SMP_W-1:0] model_window [fpfir_pkg::TAPS];
  logic signed [fpfir_pkg::SMP_W-1:0] model_taps [fpfir_pkg::TAPS];

  logic [fpfir_pkg::SMP_W-1:0] expected_filtered [$];
  logic [fpfir_pkg::SMP_W-1:0] want;
  int                          mismatches;
  int                          snd_idle_pct;
  int                          rcv_idle_pct;
  int                          hold_requests;
  int                          holds_served;

  stim_row_t directed [22] = '{
    // taps are all zero after reset, whatever comes in
    '{fpfir_pkg::MODE_SAMPLE, 16'h0000, 4'h0, 16'h0000, 1'b1, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h7FFF, 4'hF, 16'hFFFF, 1'b1, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'hA, 16'h5555, 1'b1, 16'h0000},
    // tap 0 = -1.0; sample field carries junk
    '{fpfir_pkg::MODE_COEF,   16'hFFFF, 4'h0, 16'h8000, 1'b0, 16'h0000},
    // -1.0 * -1.0 = +1.0 wraps to -1.0
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'h5, 16'h1234, 1'b1, 16'h8000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h7FFF, 4'h0, 16'h0000, 1'b1, 16'h8001},
    // smallest tap: rounding around one half
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'h0, 16'h0001, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h4000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'hC000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h3FFF, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'hC001, 4'h0, 16'h0000, 1'b0, 16'h0000},
    // last slot at maximum, first four at minimum
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'hF, 16'h7FFF, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_COEF,   16'h1234, 4'h1, 16'h8000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'h2, 16'h8000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'h3, 16'h8000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'h0, 16'h8000, 1'b0, 16'h0000},
    // large sums that wrap
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h8000, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_SAMPLE, 16'h7FFF, 4'h0, 16'h0000, 1'b0, 16'h0000},
    '{fpfir_pkg::MODE_COEF,   16'h0000, 4'hF, 16'h0000, 1'b0, 16'h0000}
  };

  fixed_point_fir_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the model by one item; return 1 when it yields a filtered value
  function automatic bit fir_model_step(fpfir_pkg::mode_t mode,
                                        logic [fpfir_pkg::SMP_W-1:0] sample,
                                        logic [fpfir_pkg::IDX_W-1:0] idx,
                                        logic [fpfir_pkg::SMP_W-1:0] value,
                                        output logic [fpfir_pkg::SMP_W-1:0] y);
    longint acc;
    longint rounded;
    longint half;
    half = longint'(1) <<< (fpfir_pkg::FRAC_W - 1);
    y = '0;
    if (mode == fpfir_pkg::MODE_COEF) begin
      if (int'(idx) < fpfir_pkg::TAPS) model_taps[idx] = value;
      return 1'b0;
    end
    for (int j = fpfir_pkg::TAPS - 1; j > 0; j--) model_window[j] = model_window[j-1];
    model_window[0] = sample;
    acc = 0;
    for (int j = 0; j < fpfir_pkg::TAPS; j++)
      acc += longint'(model_window[j]) * longint'(model_taps[j]);
    // half away from zero, then wrap
    if (acc >= 0) rounded = (acc + half) >>> fpfir_pkg::FRAC_W;
    else          rounded = -((-acc + half) >>> fpfir_pkg::FRAC_W);
    y = rounded[fpfir_pkg::SMP_W-1:0];
    return 1'b1;
  endfunction

  // Mostly random, with a fair share of the Q15 extremes
  function automatic logic [fpfir_pkg::SMP_W-1:0] pick_q15();
    logic [fpfir_pkg::SMP_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'h0000;
      3:       v = 16'($urandom_range(64)) - 16'd32;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Offer one item, starting at a falling edge; return at the falling edge after it
  task automatic send_item(fpfir_pkg::mode_t mode, logic [fpfir_pkg::SMP_W-1:0] sample,
                           logic [fpfir_pkg::IDX_W-1:0] idx,
                           logic [fpfir_pkg::SMP_W-1:0] value, logic typed,
                           logic [fpfir_pkg::SMP_W-1:0] typed_result);
    logic [fpfir_pkg::SMP_W-1:0] y;
    bit                          gives;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= fpfir_pkg::IN_DATA_W'({value, idx, sample});
    do @(posedge clk); while (!in_tready);
    gives = fir_model_step(mode, sample, idx, value, y);
    if (gives) expected_filtered = {expected_filtered, (typed ? typed_result : y)};
    @(negedge clk);
  endtask

  task automatic run_random(int count, int snd_pct, int rcv_pct, bit with_hold);
    fpfir_pkg::mode_t mode;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) hold_requests++;
      mode = ($urandom_range(99) < 15) ? fpfir_pkg::MODE_COEF : fpfir_pkg::MODE_SAMPLE;
      send_item(mode, pick_q15(), 4'($urandom_range(15)), pick_q15(), 1'b0, '0);
    end
  endtask

  // Sender
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    hold_requests = 0;
    snd_idle_pct  = 23;
    rcv_idle_pct  = 76;
    for (int j = 0; j < fpfir_pkg::TAPS; j++) begin
      model_window[j] = '0;
      model_taps[j]   = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].sample, directed[i].idx,
                directed[i].value, directed[i].typed, directed[i].result);

    run_random(RAND_PHASE, 23, 76, 1'b1);
    // pause until the pipeline has drained
    in_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(negedge clk);
    run_random(RAND_PHASE, 76, 23, 1'b0);
    run_random(RAND_PHASE, 0, 0, 1'b1);
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (expected_filtered.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left    = 0;
    holds_served = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Check each filtered item against the oldest expectation
  initial mismatches = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_filtered.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected filtered item: actual %h", out_tdata);
      end else begin
        want = expected_filtered.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("filtered mismatch: expected %h actual %h", want, out_tdata);
        end
      end
    end
  end

  // Hard stop
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ fixed_point_fir_filter.f @@
rtl/core/fpfir_pkg.sv
rtl/core/fpfir_cell.sv
rtl/core/fpfir_sum_tree.sv
rtl/core/fixed_point_fir_filter.sv
tb/sv/fixed_point_fir_filter_test.sv
